### design/cbpf_pkg.sv
// ----------------------------------------------------------------------------
// cbpf_pkg
// Shared types, constants and helpers of the cubic Bezier path flattener.
// ----------------------------------------------------------------------------
package cbpf_pkg;

	// defaults for the top-level parameters
	localparam int STEPS_DEF     = 20;
	localparam int FRAC_BITS_DEF = 16;

	// stream widths
	localparam int COORD_W   = 32;
	localparam int IN_DATA_W = 6 * COORD_W;
	localparam int IN_USER_W = 3;
	localparam int OUT_DATA_W = 2 * COORD_W;

	// coefficient, shifted term and sum widths
	localparam int DIFF3_W = COORD_W + 3;
	localparam int CW      = COORD_W + 4;
	localparam int TERM_W  = CW + 2;
	localparam int SUM_W   = CW + 4;

	localparam logic signed [COORD_W-1:0] COORD_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] COORD_MIN = 32'sh8000_0000;

	typedef enum logic [1:0] {
		OP_VERTEX = 2'd0,
		OP_BEZIER = 2'd1,
		OP_END    = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_COEF,
		ST_ISSUE
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic ld_coef1;
		logic ld_coef2;
		logic ld_pt_in;
		logic ld_pt_start;
		logic set_prev;
		logic set_start;
		logic clr_path;
		logic t_clear;
		logic issue;
		logic last;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic adv;
		logic busy;
	} stat_t;

	// 3 * (a - b) at full precision
	function automatic logic signed [DIFF3_W-1:0] triple_diff(
		input logic signed [COORD_W-1:0] a,
		input logic signed [COORD_W-1:0] b
	);
		logic signed [DIFF3_W-1:0] d;
		d = DIFF3_W'(a) - DIFF3_W'(b);
		return d + (d <<< 1);
	endfunction

	function automatic logic signed [COORD_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
		logic signed [COORD_W-1:0] r;
		if (v > SUM_W'(COORD_MAX)) begin
			r = COORD_MAX;
		end else if (v < SUM_W'(COORD_MIN)) begin
			r = COORD_MIN;
		end else begin
			r = COORD_W'(v);
		end
		return r;
	endfunction

endpackage

### design/cbpf_datapath.sv
// ----------------------------------------------------------------------------
// cbpf_datapath
// Path point registers, coefficient registers, parameter generator and the
// evaluation pipeline with its output register.
// ----------------------------------------------------------------------------
module cbpf_datapath #(
	parameter int STEPS     = cbpf_pkg::STEPS_DEF,
	parameter int FRAC_BITS = cbpf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  cbpf_pkg::cmd_t                      cmd,
	output cbpf_pkg::stat_t                     stat,
	input  logic [cbpf_pkg::IN_DATA_W-1:0]      s_data,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	output logic [cbpf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // out_x, out_y
	output logic                                m_axis_tlast
);

	localparam int CW_L   = cbpf_pkg::CW;
	localparam int TW     = FRAC_BITS + 1;
	localparam int PW     = CW_L + TW + 1;
	localparam int DIV    = STEPS - 1;
	localparam int Q0     = (1 << FRAC_BITS) / DIV;
	localparam int R0     = (1 << FRAC_BITS) % DIV;
	localparam int RW     = $clog2(STEPS) + 1;
	localparam int CRD_W  = cbpf_pkg::COORD_W;
	localparam int D3_W   = cbpf_pkg::DIFF3_W;
	localparam int TRM_W  = cbpf_pkg::TERM_W;
	localparam int SM_W   = cbpf_pkg::SUM_W;

	logic signed [CRD_W-1:0] end_pt [2];
	logic signed [CRD_W-1:0] c1_pt  [2];
	logic signed [CRD_W-1:0] c2_pt  [2];

	logic signed [CRD_W-1:0] prev_q  [2];
	logic signed [CRD_W-1:0] start_q [2];
	logic signed [CRD_W-1:0] p0_q    [2];
	logic signed [D3_W-1:0]  cx_q    [2];
	logic signed [D3_W-1:0]  d21_q   [2];
	logic signed [CRD_W:0]   e0_q    [2];
	logic signed [CW_L-1:0]  bx_q    [2];
	logic signed [CW_L-1:0]  ax_q    [2];

	logic [TW-1:0] t_q;
	logic [RW-1:0] r_q;
	logic [RW-1:0] r_sum;

	logic          en;
	logic [2*TW-1:0] tsq;
	logic [2*TW-1:0] tcube;

	logic          v_s1, v_s2, v_s3, v_s4;
	logic          last_s1, last_s2, last_s3, last_s4;
	logic [TW-1:0] t_s1, t2_s1, t_s2, t2_s2, t3_s2;

	logic signed [PW-1:0]    pa [2];
	logic signed [PW-1:0]    pb [2];
	logic signed [PW-1:0]    pc [2];
	logic signed [TRM_W-1:0] ta_s3 [2];
	logic signed [TRM_W-1:0] tb_s3 [2];
	logic signed [TRM_W-1:0] tc_s3 [2];
	logic signed [SM_W-1:0]  sab_s4 [2];
	logic signed [SM_W-1:0]  scp_s4 [2];
	logic signed [SM_W-1:0]  sum    [2];

	logic                    m_valid_q;
	logic                    m_last_q;
	logic signed [CRD_W-1:0] m_pt_q [2];

	assign end_pt[0] = s_data[31:0];
	assign end_pt[1] = s_data[63:32];
	assign c1_pt[0]  = s_data[95:64];
	assign c1_pt[1]  = s_data[127:96];
	assign c2_pt[0]  = s_data[159:128];
	assign c2_pt[1]  = s_data[191:160];

	// the whole pipeline moves when the output register is free or being taken
	assign en = !m_valid_q || m_axis_tready;

	assign stat.adv  = en;
	assign stat.busy = v_s1 || v_s2 || v_s3 || v_s4;

	// path state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				prev_q[k]  <= '0;
				start_q[k] <= '0;
			end
		end else if (cmd.clr_path) begin
			for (int k = 0; k < 2; k++) begin
				prev_q[k]  <= '0;
				start_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < 2; k++) begin
				if (cmd.set_prev) begin
					prev_q[k] <= end_pt[k];
				end
				if (cmd.set_start) begin
					start_q[k] <= end_pt[k];
				end
			end
		end
	end

	// coefficients: c = 3(p1-p0), b = 3(p2-p1) - c, a = (p3-p0) - 3(p2-p1)
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 2; k++) begin
				cx_q[k]  <= '0;
				d21_q[k] <= '0;
				e0_q[k]  <= '0;
				p0_q[k]  <= '0;
				bx_q[k]  <= '0;
				ax_q[k]  <= '0;
			end
		end else begin
			for (int k = 0; k < 2; k++) begin
				if (cmd.ld_coef1) begin
					cx_q[k]  <= cbpf_pkg::triple_diff(c1_pt[k], prev_q[k]);
					d21_q[k] <= cbpf_pkg::triple_diff(c2_pt[k], c1_pt[k]);
					e0_q[k]  <= (CRD_W + 1)'(end_pt[k]) - (CRD_W + 1)'(prev_q[k]);
					p0_q[k]  <= prev_q[k];
				end else if (cmd.ld_pt_in) begin
					p0_q[k] <= end_pt[k];
				end else if (cmd.ld_pt_start) begin
					p0_q[k] <= start_q[k];
				end
				if (cmd.ld_coef2) begin
					bx_q[k] <= CW_L'(d21_q[k]) - CW_L'(cx_q[k]);
					ax_q[k] <= CW_L'(e0_q[k]) - CW_L'(d21_q[k]);
				end
			end
		end
	end

	// t = floor(i * 2^F / (STEPS-1)), kept as quotient and remainder
	assign r_sum = r_q + RW'(R0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			t_q <= '0;
			r_q <= '0;
		end else if (cmd.t_clear) begin
			t_q <= '0;
			r_q <= '0;
		end else if (cmd.issue) begin
			if (r_sum >= RW'(DIV)) begin
				t_q <= t_q + TW'(Q0) + TW'(1);
				r_q <= r_sum - RW'(DIV);
			end else begin
				t_q <= t_q + TW'(Q0);
				r_q <= r_sum;
			end
		end
	end

	assign tsq   = (2 * TW)'(t_q) * (2 * TW)'(t_q);
	assign tcube = (2 * TW)'(t2_s1) * (2 * TW)'(t_s1);

	always_comb begin
		for (int k = 0; k < 2; k++) begin
			pa[k] = PW'(ax_q[k]) * PW'($signed({1'b0, t3_s2}));
			pb[k] = PW'(bx_q[k]) * PW'($signed({1'b0, t2_s2}));
			pc[k] = PW'(cx_q[k]) * PW'($signed({1'b0, t_s2}));
			sum[k] = sab_s4[k] + scp_s4[k];
		end
	end

	// stage valid bits and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			m_valid_q <= 1'b0;
		end else if (en) begin
			v_s1      <= cmd.issue;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			m_valid_q <= v_s4;
		end
	end

	// stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			t_s1    <= t_q;
			t2_s1   <= tsq[FRAC_BITS +: TW];
			last_s1 <= cmd.last;

			t_s2    <= t_s1;
			t2_s2   <= t2_s1;
			t3_s2   <= tcube[FRAC_BITS +: TW];
			last_s2 <= last_s1;

			last_s3 <= last_s2;
			last_s4 <= last_s3;
			for (int k = 0; k < 2; k++) begin
				ta_s3[k]  <= TRM_W'(pa[k] >>> FRAC_BITS);
				tb_s3[k]  <= TRM_W'(pb[k] >>> FRAC_BITS);
				tc_s3[k]  <= TRM_W'(pc[k] >>> FRAC_BITS);
				sab_s4[k] <= SM_W'(ta_s3[k]) + SM_W'(tb_s3[k]);
				scp_s4[k] <= SM_W'(tc_s3[k]) + SM_W'(p0_q[k]);
			end
			if (v_s4) begin
				m_last_q <= last_s4;
				for (int k = 0; k < 2; k++) begin
					m_pt_q[k] <= cbpf_pkg::sat32(sum[k]);
				end
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {m_pt_q[1], m_pt_q[0]};
	assign m_axis_tlast  = m_last_q;

endmodule

### design/cbpf_ctrl.sv
// ----------------------------------------------------------------------------
// cbpf_ctrl
// Command decoder and vertex sequencer of the path flattener.
// ----------------------------------------------------------------------------
module cbpf_ctrl #(
	parameter int STEPS = cbpf_pkg::STEPS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_axis_tvalid,
	output logic            s_axis_tready,
	input  logic [1:0]      opcode,
	input  logic            close_path,
	input  cbpf_pkg::stat_t stat,
	output cbpf_pkg::cmd_t  cmd
);

	localparam int CNTW = $clog2(STEPS);
	localparam logic [CNTW-1:0] LAST_IDX = CNTW'(STEPS - 1);

	cbpf_pkg::state_t state_q, state_d;
	logic             have_point_q, have_point_d;
	logic [CNTW-1:0]  count_q, count_d;
	logic             single_q, single_d;
	logic             accept;

	assign s_axis_tready = (state_q == cbpf_pkg::ST_IDLE) && !stat.busy;
	assign accept        = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= cbpf_pkg::ST_IDLE;
			have_point_q <= 1'b0;
			count_q      <= '0;
			single_q     <= 1'b0;
		end else begin
			state_q      <= state_d;
			have_point_q <= have_point_d;
			count_q      <= count_d;
			single_q     <= single_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		have_point_d = have_point_q;
		count_d      = count_q;
		single_d     = single_q;
		cmd          = '0;
		unique case (state_q)
			cbpf_pkg::ST_IDLE: begin
				if (accept) begin
					count_d = '0;
					unique case (opcode)
						cbpf_pkg::OP_VERTEX: begin
							cmd.ld_pt_in  = 1'b1;
							cmd.set_prev  = 1'b1;
							cmd.set_start = !have_point_q;
							cmd.t_clear   = 1'b1;
							have_point_d  = 1'b1;
							single_d      = 1'b1;
							state_d       = cbpf_pkg::ST_ISSUE;
						end
						cbpf_pkg::OP_BEZIER: begin
							// a segment needs a previous point; drop it otherwise
							if (have_point_q) begin
								cmd.ld_coef1 = 1'b1;
								cmd.set_prev = 1'b1;
								cmd.t_clear  = 1'b1;
								single_d     = 1'b0;
								state_d      = cbpf_pkg::ST_COEF;
							end
						end
						cbpf_pkg::OP_END: begin
							if (close_path && have_point_q) begin
								cmd.ld_pt_start = 1'b1;
								cmd.t_clear     = 1'b1;
								single_d        = 1'b1;
								state_d         = cbpf_pkg::ST_ISSUE;
							end
							cmd.clr_path = 1'b1;
							have_point_d = 1'b0;
						end
						default: begin
						end
					endcase
				end
			end
			cbpf_pkg::ST_COEF: begin
				cmd.ld_coef2 = 1'b1;
				state_d      = cbpf_pkg::ST_ISSUE;
			end
			cbpf_pkg::ST_ISSUE: begin
				if (stat.adv) begin
					cmd.issue = 1'b1;
					cmd.last  = single_q || (count_q == LAST_IDX);
					if (cmd.last) begin
						state_d = cbpf_pkg::ST_IDLE;
					end else begin
						count_d = count_q + CNTW'(1);
					end
				end
			end
			default: begin
				state_d = cbpf_pkg::ST_IDLE;
			end
		endcase
	end

	a_issue_on_adv: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> stat.adv)
		else $error("vertex issued while the pipeline is stalled");

	a_accept_when_drained: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !stat.busy)
		else $error("command accepted with the pipeline still busy");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == cbpf_pkg::ST_ISSUE) |-> (count_q <= LAST_IDX))
		else $error("vertex counter past the last step");

	a_bezier_coef: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == cbpf_pkg::OP_BEZIER && have_point_q)
			|=> (state_q == cbpf_pkg::ST_COEF))
		else $error("bezier segment did not start coefficient setup");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && opcode == cbpf_pkg::OP_END) |=> !have_point_q)
		else $error("end command left the path open");

endmodule

### design/cubic_bezier_path_flattener.sv
// ----------------------------------------------------------------------------
// cubic_bezier_path_flattener
// Turns path commands into a stream of Q16.16 vertices.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on the s_axis channel: tuser carries the opcode and the
//   close flag, tdata the end point and the two control points. Vertices
//   leave on the m_axis channel as (x, y) words; tlast marks the final vertex
//   caused by one command.
//   A vertex command yields one word, a Bezier segment STEPS words, an end
//   command with close set one word (the first point of the path); the
//   latter two yield nothing while the path has no point. Each word passes
//   the evaluation stages s1 to s4 and then the output register. A segment
//   first forms its coefficients in a state of its own, then streams one
//   word per cycle while the receiver keeps up. The next command is taken
//   once the 4-stage evaluation pipeline has drained.
//   When the receiver stalls, the output register and the whole pipeline
//   hold; no word is lost. A finished word waiting in the output register
//   does not block acceptance of the next command.
//   Reset clears the path (no previous or first point) and empties the
//   pipeline; it takes effect at once.
// ----------------------------------------------------------------------------
module cubic_bezier_path_flattener #(
	parameter int STEPS     = cbpf_pkg::STEPS_DEF,
	parameter int FRAC_BITS = cbpf_pkg::FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	// end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y
	input  logic [cbpf_pkg::IN_DATA_W-1:0]      s_axis_tdata,
	// opcode, close_path
	input  logic [cbpf_pkg::IN_USER_W-1:0]      s_axis_tuser,
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// out_x, out_y
	output logic [cbpf_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
	output logic                                m_axis_tlast
);

	cbpf_pkg::cmd_t  cmd;
	cbpf_pkg::stat_t stat;

	cbpf_ctrl #(
		.STEPS (STEPS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.opcode        (s_axis_tuser[1:0]),
		.close_path    (s_axis_tuser[2]),
		.stat          (stat),
		.cmd           (cmd)
	);

	cbpf_datapath #(
		.STEPS     (STEPS),
		.FRAC_BITS (FRAC_BITS)
	) u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.s_data        (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

endmodule

### verif/cubic_bezier_path_flattener_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cubic_bezier_path_flattener_test
// Self-checking bench for the path flattener. Path commands are streamed into
// the block under random stalls on both channels. Each accepted command is run
// through a Q16.16 flattening predictor, and every vertex word that leaves the
// block is compared with the oldest predicted word.
// ----------------------------------------------------------------------------
module cubic_bezier_path_flattener_test;

	localparam int STEPS      = cbpf_pkg::STEPS_DEF;
	localparam int FRAC_BITS  = cbpf_pkg::FRAC_BITS_DEF;
	localparam int COORD_W    = cbpf_pkg::COORD_W;
	localparam int IN_DATA_W  = cbpf_pkg::IN_DATA_W;
	localparam int IN_USER_W  = cbpf_pkg::IN_USER_W;
	localparam int OUT_DATA_W = cbpf_pkg::OUT_DATA_W;
	localparam int HALF       = 5;
	localparam int LIMIT      = 400000;
	localparam int TAIL       = STEPS + 20;
	localparam int RANDOM_N   = 84;

	localparam cbpf_pkg::op_t OP_VERTEX = cbpf_pkg::OP_VERTEX;
	localparam cbpf_pkg::op_t OP_BEZIER = cbpf_pkg::OP_BEZIER;
	localparam cbpf_pkg::op_t OP_END    = cbpf_pkg::OP_END;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef logic signed [COORD_W-1:0] coord_t;

	localparam coord_t COORD_MAX = cbpf_pkg::COORD_MAX;
	localparam coord_t COORD_MIN = cbpf_pkg::COORD_MIN;

	typedef struct {
		logic [1:0] opcode;
		coord_t     end_x, end_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y;
		logic       close_path;
	} path_cmd_t;

	typedef struct {
		coord_t x, y;
		logic   last;
	} vertex_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [IN_USER_W-1:0]  s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic                  m_axis_tlast;

	path_cmd_t pending_cmds[$];
	vertex_t   due_vertices[$];

	// predicted path state
	coord_t path_prev_x  = '0;
	coord_t path_prev_y  = '0;
	coord_t path_start_x = '0;
	coord_t path_start_y = '0;
	bit     path_open    = 1'b0;

	int total_cmds    = 0;
	int live_cmds     = 0;
	int cmds_taken    = 0;
	int words_checked = 0;
	int mismatches    = 0;
	int segments_run  = 0;
	int closes_run    = 0;
	int cycles        = 0;

	cubic_bezier_path_flattener #(
		.STEPS     (STEPS),
		.FRAC_BITS (FRAC_BITS)
	) i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #HALF clk = ~clk;

	function automatic coord_t fx(int whole);
		return coord_t'(whole) <<< FRAC_BITS;
	endfunction

	function automatic coord_t rand_coord(bit wide);
		if (!wide) begin
			// about +-1024.0, keeps curves inside the range
			return coord_t'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
		end
		case ($urandom_range(0, 5))
			0: return COORD_MAX;
			1: return COORD_MIN;
			2: return coord_t'({($urandom_range(0, 1) != 0) ? 4'h7 : 4'h8, 28'($urandom)});
			default: return coord_t'($urandom);
		endcase
	endfunction

	function automatic int idle_pct(bit rx);
		int phase;
		phase = (total_cmds == 0) ? 0 : cmds_taken * 3 / total_cmds;
		case (phase)
			0: return rx ? 76 : 14;
			1: return rx ? 14 : 76;
			default: return 0;
		endcase
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > longint'(COORD_MAX)) begin
			return COORD_MAX;
		end else if (v < longint'(COORD_MIN)) begin
			return COORD_MIN;
		end
		return coord_t'(v);
	endfunction

	// one axis of p(t) = a t^3 + b t^2 + c t + p0, terms floored separately
	function automatic coord_t curve_axis(longint p0, longint p1, longint p2, longint p3,
			longint t, longint t2, longint t3);
		longint c, b, a;
		c = 3 * (p1 - p0);
		b = 3 * (p2 - p1) - c;
		a = p3 - p0 - c - b;
		return clamp_coord(((a * t3) >>> FRAC_BITS) + ((b * t2) >>> FRAC_BITS)
			+ ((c * t) >>> FRAC_BITS) + p0);
	endfunction

	task automatic flatten_cmd(path_cmd_t cmd);
		vertex_t v;
		longint  t, t2, t3;
		int      i;
		case (cmd.opcode)
			OP_VERTEX: begin
				v.x    = cmd.end_x;
				v.y    = cmd.end_y;
				v.last = 1'b1;
				due_vertices = {due_vertices, v};
				if (!path_open) begin
					path_start_x = cmd.end_x;
					path_start_y = cmd.end_y;
					path_open    = 1'b1;
				end
				path_prev_x = cmd.end_x;
				path_prev_y = cmd.end_y;
			end
			OP_BEZIER: begin
				// a segment needs a previous point
				if (path_open) begin
					segments_run++;
					for (i = 0; i < STEPS; i++) begin
						t      = (longint'(i) <<< FRAC_BITS) / (STEPS - 1);
						t2     = (t * t) >>> FRAC_BITS;
						t3     = (t2 * t) >>> FRAC_BITS;
						v.x    = curve_axis(path_prev_x, cmd.ctrl1_x, cmd.ctrl2_x, cmd.end_x,
							t, t2, t3);
						v.y    = curve_axis(path_prev_y, cmd.ctrl1_y, cmd.ctrl2_y, cmd.end_y,
							t, t2, t3);
						v.last = (i == STEPS - 1);
						due_vertices = {due_vertices, v};
					end
					path_prev_x = v.x;
					path_prev_y = v.y;
				end
			end
			OP_END: begin
				if (cmd.close_path && path_open) begin
					closes_run++;
					v.x    = path_start_x;
					v.y    = path_start_y;
					v.last = 1'b1;
					due_vertices = {due_vertices, v};
				end
				path_prev_x  = '0;
				path_prev_y  = '0;
				path_start_x = '0;
				path_start_y = '0;
				path_open    = 1'b0;
			end
			default: begin
			end
		endcase
	endtask

	task automatic queue_cmd(logic [1:0] opcode, coord_t end_x, coord_t end_y,
			coord_t ctrl1_x, coord_t ctrl1_y, coord_t ctrl2_x, coord_t ctrl2_y,
			logic close_path);
		path_cmd_t cmd;
		cmd.opcode     = opcode;
		cmd.end_x      = end_x;
		cmd.end_y      = end_y;
		cmd.ctrl1_x    = ctrl1_x;
		cmd.ctrl1_y    = ctrl1_y;
		cmd.ctrl2_x    = ctrl2_x;
		cmd.ctrl2_y    = ctrl2_y;
		cmd.close_path = close_path;
		pending_cmds = {pending_cmds, cmd};
		if (opcode != OP_UNUSED) begin
			live_cmds++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : cmd_driver
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				flatten_cmd(pending_cmds.pop_front());
				cmds_taken <= cmds_taken + 1;
			end
			// hold an offered word until it is taken
			if (!s_axis_tvalid || s_axis_tready) begin
				if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
					s_axis_tvalid <= 1'b1;
					s_axis_tdata  <= {pending_cmds[0].ctrl2_y, pending_cmds[0].ctrl2_x,
						pending_cmds[0].ctrl1_y, pending_cmds[0].ctrl1_x,
						pending_cmds[0].end_y, pending_cmds[0].end_x};
					s_axis_tuser  <= {pending_cmds[0].close_path, pending_cmds[0].opcode};
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : vertex_monitor
		vertex_t want;
		coord_t  got_x, got_y;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_x = m_axis_tdata[COORD_W-1:0];
				got_y = m_axis_tdata[2*COORD_W-1:COORD_W];
				if (due_vertices.size() == 0) begin
					$error("unexpected word: x %0d, y %0d, last %0b", got_x, got_y, m_axis_tlast);
					mismatches++;
				end else begin
					want = due_vertices.pop_front();
					words_checked++;
					if (got_x !== want.x) begin
						$error("out_x: expected %0d, got %0d", want.x, got_x);
						mismatches++;
					end
					if (got_y !== want.y) begin
						$error("out_y: expected %0d, got %0d", want.y, got_y);
						mismatches++;
					end
					if (m_axis_tlast !== want.last) begin
						$error("last_of_run: expected %0b, got %0b", want.last, m_axis_tlast);
						mismatches++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
		end
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == LIMIT) begin
			$error("timeout: %0d commands unsent, %0d words outstanding",
				pending_cmds.size(), due_vertices.size());
			$display("** cubic_bezier_path_flattener: FAILED **");
			$finish;
		end
	end

	initial begin : stimulus
		int     directed_live, seg_count;
		bit     wide;
		coord_t junk;
		junk = '1;

		// paths that are empty: nothing comes out
		queue_cmd(OP_BEZIER, fx(1), fx(1), fx(1), fx(1), fx(1), fx(1), 1'b0);
		queue_cmd(OP_END, fx(3), fx(3), '0, '0, '0, '0, 1'b1);
		queue_cmd(OP_END, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_UNUSED, junk, junk, junk, junk, junk, junk, 1'b1);

		// ordinary path, some unused fields all ones, unused opcode in the middle
		queue_cmd(OP_VERTEX, '0, '0, junk, junk, junk, junk, 1'b1);
		queue_cmd(OP_BEZIER, fx(10), fx(0), fx(2), fx(5), fx(8), fx(5), 1'b0);
		queue_cmd(OP_VERTEX, fx(12) + 32'sh8000, fx(-3) - 32'sh4000, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_BEZIER, fx(-7), fx(-20), fx(-100), fx(40), fx(30), fx(-60), 1'b1);
		queue_cmd(OP_UNUSED, fx(9), fx(9), fx(9), fx(9), fx(9), fx(9), 1'b0);
		queue_cmd(OP_BEZIER, fx(1), fx(1), fx(1), fx(1), fx(1), fx(1), 1'b0);
		queue_cmd(OP_END, junk, junk, junk, junk, junk, junk, 1'b1);

		// extreme corners: drive the sums into saturation
		queue_cmd(OP_VERTEX, COORD_MAX, COORD_MAX, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_BEZIER, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX,
			1'b0);
		queue_cmd(OP_BEZIER, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN,
			1'b0);
		queue_cmd(OP_VERTEX, COORD_MIN, COORD_MIN, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_END, '0, '0, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_VERTEX, COORD_MIN, COORD_MAX, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_BEZIER, COORD_MAX, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX,
			1'b0);
		queue_cmd(OP_END, '0, '0, '0, '0, '0, '0, 1'b1);

		// degenerate curve, every coordinate one LSB from zero
		queue_cmd(OP_VERTEX, -32'sd1, 32'sd1, '0, '0, '0, '0, 1'b0);
		queue_cmd(OP_BEZIER, -32'sd1, 32'sd1, 32'sd1, -32'sd1, -32'sd1, 32'sd1, 1'b0);
		queue_cmd(OP_END, '0, '0, '0, '0, '0, '0, 1'b1);

		// random paths, mostly well formed, the rest noise
		directed_live = live_cmds;
		while (live_cmds < directed_live + RANDOM_N) begin
			if ($urandom_range(0, 99) < 80) begin
				wide = ($urandom_range(0, 3) == 0);
				queue_cmd(OP_VERTEX, rand_coord(wide), rand_coord(wide), $urandom, $urandom,
					$urandom, $urandom, 1'($urandom_range(0, 1)));
				seg_count = $urandom_range(1, 4);
				repeat (seg_count) begin
					if ($urandom_range(0, 5) == 0) begin
						queue_cmd(OP_VERTEX, rand_coord(wide), rand_coord(wide), $urandom,
							$urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
					end
					queue_cmd(OP_BEZIER, rand_coord(wide), rand_coord(wide), rand_coord(wide),
						rand_coord(wide), rand_coord(wide), rand_coord(wide),
						1'($urandom_range(0, 1)));
				end
				queue_cmd(OP_END, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom_range(0, 3) != 0);
			end else begin
				queue_cmd(2'($urandom_range(0, 3)), rand_coord(1'b1), rand_coord(1'b1),
					rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1),
					1'($urandom_range(0, 1)));
			end
		end
		total_cmds = pending_cmds.size();

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (pending_cmds.size() != 0 || s_axis_tvalid || due_vertices.size() != 0);
		// give a trailing command that yields nothing time to leave the pipeline
		repeat (TAIL) @(negedge clk);

		$display("Sent %0d commands: %0d segments flattened, %0d paths closed.",
			total_cmds, segments_run, closes_run);
		$display("Checked %0d vertex words, %0d mismatches.", words_checked, mismatches);
		if (mismatches == 0) begin
			$display("** cubic_bezier_path_flattener: PASSED **");
		end else begin
			$display("** cubic_bezier_path_flattener: FAILED **");
		end
		$finish;
	end

endmodule

### cubic_bezier_path_flattener.f
design/cbpf_pkg.sv
design/cbpf_datapath.sv
design/cbpf_ctrl.sv
design/cubic_bezier_path_flattener.sv
verif/cubic_bezier_path_flattener_test.sv
